// File: rtl/dkns_pkg.sv
// Package: shared types, constants and the frequency function of the keypad note selector.
`timescale 1ns / 1ps
package dkns_pkg;

  localparam int QUIET_W    = 9;
  localparam int BUTTONS    = 3;
  localparam int SHIFT_W    = 4;
  localparam int HOLD_W     = 14;
  localparam int NOTE_IDX_W = 5;
  localparam int NOTE_W     = 4;
  localparam int FREQ_W     = 17;
  localparam int DEB_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [QUIET_W-1:0] QUIET_MAX     = '1;
  localparam logic [HOLD_W-1:0]  HOLD_MAX      = '1;
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = 8'd50;
  localparam logic [HOLD_W-1:0]  LONG_PRESS_RST = 14'd7000;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 2'd1;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } ram_ctl_t;

  // one item's state after the debounce/note update, ahead of the frequency stage
  typedef struct packed {
    logic                       valid;
    action_t                    action;
    logic                       note_valid;
    logic [NOTE_IDX_W-1:0]      note_idx;
    logic signed [SHIFT_W-1:0]  shift;
    logic                       indicator;
    logic                       restart;
  } tone_t;

  // Hz * 256 for B down to C of the fourth octave
  localparam logic [FREQ_W-1:0] BASE_Q8 [12] = '{
    17'd126433, 17'd119337, 17'd112640, 17'd106317, 17'd100352, 17'd94717,
    17'd89403,  17'd84385,  17'd79649,  17'd75177,  17'd70958,  17'd66977
  };

  function automatic logic [3:0] mod12(input logic [NOTE_IDX_W-1:0] x);
    logic [NOTE_IDX_W-1:0] r;
    if (x >= 5'd24) r = x - 5'd24;
    else if (x >= 5'd12) r = x - 5'd12;
    else r = x;
    return r[3:0];
  endfunction

  // base * 2^shift / 16, rounded half up, saturated
  function automatic logic [FREQ_W-1:0] freq_q4(input logic [NOTE_IDX_W-1:0] idx,
                                                input logic signed [SHIFT_W-1:0] s);
    logic [20:0]       t;
    logic [20:0]       r;
    logic signed [4:0] d;
    logic [3:0]        sh;
    logic [1:0]        shl;
    t = 21'(BASE_Q8[mod12(idx)]);
    d = 5'sd4 - 5'(s);
    sh = 4'(d);
    shl = 2'(s - 4'sd4);
    if (s >= 4'sd4) r = t << shl;
    else r = (t + (21'd1 << (sh - 4'd1))) >> sh;
    if (r > 21'(FREQ_W'('1))) return '1;
    return r[FREQ_W-1:0];
  endfunction

endpackage

// File: rtl/dkns_sample_if.sv
// Interface: sample channel carrying raw key and button levels.
`timescale 1ns / 1ps
interface dkns_sample_if #(parameter int NUM_KEYS = 12);
  logic                valid;
  logic                ready;
  logic [NUM_KEYS-1:0] keys;
  logic                up_button;
  logic                down_button;
  logic                mode_button;

  modport source (output valid, keys, up_button, down_button, mode_button, input ready);
  modport sink   (input valid, keys, up_button, down_button, mode_button, output ready);
endinterface

// File: rtl/dkns_result_if.sv
// Interface: result channel carrying tone action, note and frequency.
`timescale 1ns / 1ps
interface dkns_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  note;
  logic [16:0] frequency_q4;
  logic        indicator;
  logic        restart;

  modport source (output valid, action, note, frequency_q4, indicator, restart, input ready);
  modport sink   (input valid, action, note, frequency_q4, indicator, restart, output ready);
endinterface

// File: rtl/dkns_cfg_if.sv
// Interface: configuration write channel.
`timescale 1ns / 1ps
interface dkns_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/debounced_keypad_note_selector_unit.sv
// Top level: debounced keypad note selector.
//
//   channel    dir  handshake    payload
//   sample_ch  in   valid/ready  keys, up_button, down_button, mode_button
//   result_ch  out  valid/ready  action, note, frequency_q4, indicator, restart
//   cfg_ch     in   valid/ready  index, data (0 debounce_ms, 1 long_press_ms)
//
// One item per cycle while result_ch is not stalled; stages: quiet-count row read, update, frequency.
// The quiet counts of all lines live in one memory row, read when an item is
// taken and written back when the update stage advances; a back-to-back read is forwarded.
// A held result stalls the whole pipe; sample_ch.ready drops in that cycle.
// Synchronous reset; the count row reads as saturated until first written.
`timescale 1ns / 1ps
module debounced_keypad_note_selector_unit #(
  parameter int NUM_KEYS     = 12,
  parameter int OCTAVE_LIMIT = 4
) (
  input  logic          clk,
  input  logic          rst,
  dkns_sample_if.sink   sample_ch,
  dkns_result_if.source result_ch,
  dkns_cfg_if.sink      cfg_ch
);
  import dkns_pkg::*;

  localparam int QW = (NUM_KEYS + BUTTONS) * QUIET_W;

  logic          adv;
  ram_ctl_t      ram_ctl;
  logic [QW-1:0] quiet_rd;
  logic [QW-1:0] quiet_wr;
  tone_t         tone;

  assign adv = !(result_ch.valid && !result_ch.ready);

  dkns_line_ram #(.W(QW)) u_ram (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ram_ctl),
    .wdata (quiet_wr),
    .rdata (quiet_rd)
  );

  dkns_update #(.NUM_KEYS(NUM_KEYS), .OCTAVE_LIMIT(OCTAVE_LIMIT)) u_update (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .sample_ch (sample_ch),
    .cfg_ch    (cfg_ch),
    .quiet_rd  (quiet_rd),
    .ram_ctl   (ram_ctl),
    .quiet_wr  (quiet_wr),
    .tone      (tone)
  );

  dkns_freq u_freq (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .tone      (tone),
    .result_ch (result_ch)
  );

endmodule

// File: rtl/dkns_line_ram.sv
// Quiet-count memory: one row holding every line's count, registered read with forwarding.
`timescale 1ns / 1ps
module dkns_line_ram #(
  parameter int W = 135
) (
  input  logic               clk,
  input  logic               rst,
  input  dkns_pkg::ram_ctl_t ctl,
  input  logic [W-1:0]       wdata,
  output logic [W-1:0]       rdata
);
  import dkns_pkg::*;

  logic [W-1:0] mem [1];
  logic [W-1:0] q;
  logic [W-1:0] wlast;
  logic         row_valid;
  logic         q_init;
  logic         fwd;

  always_ff @(posedge clk) begin
    if (ctl.rd) q <= mem[0];
    if (ctl.wr) begin
      mem[0] <= wdata;
      wlast  <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
      q_init    <= 1'b1;
      fwd       <= 1'b0;
    end else begin
      if (ctl.wr) row_valid <= 1'b1;
      if (ctl.rd) begin
        q_init <= !row_valid;
        // write in the same cycle as the read: the read saw the old row
        fwd    <= ctl.wr;
      end
    end
  end

  // counts reset to all ones (saturated) until the row is first written
  assign rdata = fwd ? wlast : (q_init ? {W{1'b1}} : q);

endmodule

// File: rtl/dkns_update.sv
// Debounce, octave, hold and note-choice update stage plus configuration registers.
`timescale 1ns / 1ps
module dkns_update #(
  parameter int NUM_KEYS     = 12,
  parameter int OCTAVE_LIMIT = 4,
  localparam int QW = (NUM_KEYS + dkns_pkg::BUTTONS) * dkns_pkg::QUIET_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  dkns_sample_if.sink        sample_ch,
  dkns_cfg_if.sink           cfg_ch,
  input  logic [QW-1:0]      quiet_rd,
  output dkns_pkg::ram_ctl_t ram_ctl,
  output logic [QW-1:0]      quiet_wr,
  output dkns_pkg::tone_t    tone
);
  import dkns_pkg::*;

  localparam int NL = NUM_KEYS + BUTTONS;
  localparam int UP = NUM_KEYS;
  localparam int DN = NUM_KEYS + 1;
  localparam int MD = NUM_KEYS + 2;
  localparam logic signed [SHIFT_W-1:0] LIM = SHIFT_W'(OCTAVE_LIMIT);

  logic [DEB_W-1:0]          debounce_ms;
  logic [HOLD_W-1:0]         long_press_ms;
  logic                      bv;
  logic [NL-1:0]             raw;
  logic [NL-1:0]             level;
  logic [NL-1:0]             level_next;
  logic [NL-1:0]             take;
  logic signed [SHIFT_W-1:0] shift;
  logic signed [SHIFT_W-1:0] shift_next;
  logic [HOLD_W-1:0]         hold;
  logic [HOLD_W-1:0]         hold_next;
  logic [NOTE_IDX_W-1:0]     cur_note;
  logic [NOTE_IDX_W-1:0]     cur_note_next;
  logic [NOTE_IDX_W-1:0]     prev_note;
  logic [NOTE_IDX_W-1:0]     prev_note_next;
  logic                      note_valid;
  logic                      note_valid_next;
  logic                      change_pending;
  logic                      change_pending_next;
  logic                      found;
  logic [NOTE_IDX_W-1:0]     low;
  logic                      accept;
  tone_t                     tone_next;

  assign sample_ch.ready = adv;
  assign cfg_ch.ready    = 1'b1;
  assign accept          = sample_ch.valid && adv;
  assign ram_ctl.rd      = accept;
  assign ram_ctl.wr      = bv && adv;

  // per-line lockout debounce
  always_comb begin
    logic [QUIET_W-1:0] q;
    logic [QUIET_W-1:0] qi;
    logic               mism;
    for (int j = 0; j < NL; j++) begin
      q    = quiet_rd[j*QUIET_W +: QUIET_W];
      qi   = (q != QUIET_MAX) ? q + 1'b1 : q;
      mism = raw[j] != level[j];
      take[j] = mism && (qi > {1'b0, debounce_ms});
      quiet_wr[j*QUIET_W +: QUIET_W] = mism ? '0 : qi;
      level_next[j] = level[j] ^ take[j];
    end
  end

  always_comb begin
    logic signed [SHIFT_W-1:0] s1;
    logic                      cp;
    s1 = shift;
    if (take[UP] && level_next[UP] && shift < LIM) s1 = shift + 4'sd1;
    shift_next = s1;
    if (take[DN] && level_next[DN] && s1 > -LIM) shift_next = s1 - 4'sd1;

    if (take[MD] && level_next[MD]) hold_next = '0;
    else if (level_next[MD] && hold != HOLD_MAX) hold_next = hold + 1'b1;
    else hold_next = hold;

    found = 1'b0;
    low   = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (level_next[i]) begin
        found = 1'b1;
        low   = NOTE_IDX_W'(i);
      end
    end

    cp                  = change_pending | (|take[NUM_KEYS-1:0]);
    change_pending_next = cp;
    cur_note_next       = cur_note;
    prev_note_next      = prev_note;
    note_valid_next     = note_valid;
    tone_next.action    = ACT_NONE;
    if (found) begin
      prev_note_next  = note_valid ? cur_note : low;
      cur_note_next   = low;
      note_valid_next = 1'b1;
      if (prev_note_next != cur_note_next || cp) begin
        tone_next.action    = ACT_START;
        change_pending_next = 1'b0;
      end
    end else if (note_valid) begin
      tone_next.action = ACT_STOP;
    end

    tone_next.valid      = bv;
    tone_next.note_valid = note_valid_next;
    tone_next.note_idx   = cur_note_next;
    tone_next.shift      = shift_next;
    tone_next.indicator  = found;
    tone_next.restart    = level_next[MD] && (hold_next > long_press_ms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms    <= DEBOUNCE_RST;
      long_press_ms  <= LONG_PRESS_RST;
      bv             <= 1'b0;
      level          <= '0;
      shift          <= '0;
      hold           <= '0;
      cur_note       <= '0;
      prev_note      <= '0;
      note_valid     <= 1'b0;
      change_pending <= 1'b0;
      tone.valid     <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_DEBOUNCE_MS:   debounce_ms   <= cfg_ch.data[DEB_W-1:0];
          REG_LONG_PRESS_MS: long_press_ms <= cfg_ch.data[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (adv) begin
        bv   <= accept;
        tone <= tone_next;
        if (accept) begin
          raw <= {sample_ch.mode_button, sample_ch.down_button, sample_ch.up_button,
                  sample_ch.keys};
        end
        if (bv) begin
          level          <= level_next;
          shift          <= shift_next;
          hold           <= hold_next;
          cur_note       <= cur_note_next;
          prev_note      <= prev_note_next;
          note_valid     <= note_valid_next;
          change_pending <= change_pending_next;
        end
      end
    end
  end

endmodule

// File: rtl/dkns_freq.sv
// Frequency stage and output register of the result channel.
`timescale 1ns / 1ps
module dkns_freq (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  dkns_pkg::tone_t tone,
  dkns_result_if.source   result_ch
);
  import dkns_pkg::*;

  logic              out_valid;
  action_t           action;
  logic [NOTE_W-1:0] note;
  logic [FREQ_W-1:0] freq;
  logic              indicator;
  logic              restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tone.valid;
      action    <= tone.action;
      note      <= tone.note_valid ? tone.note_idx[NOTE_W-1:0] : '0;
      freq      <= tone.note_valid ? freq_q4(tone.note_idx, tone.shift) : '0;
      indicator <= tone.indicator;
      restart   <= tone.restart;
    end
  end

  assign result_ch.valid        = out_valid;
  assign result_ch.action       = action;
  assign result_ch.note         = note;
  assign result_ch.frequency_q4 = freq;
  assign result_ch.indicator    = indicator;
  assign result_ch.restart      = restart;

endmodule

// File: rtl/dkns_checker.sv
// Port-level checker for the keypad note selector, bound to the top level.
`timescale 1ns / 1ps
module dkns_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  action,
  input logic [3:0]  note,
  input logic [16:0] freq,
  input logic        indicator,
  input logic        restart
);
  import dkns_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({action, note, freq, indicator, restart}))
    else $error("result changed while stalled");

  a_start_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_START |-> indicator && freq != '0)
    else $error("start without a pressed key");

  a_stop_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_STOP |-> !indicator && freq != '0)
    else $error("stop with a key pressed or no note");

  a_lamp_freq: assert property (@(posedge clk) disable iff (rst)
    out_valid && indicator |-> freq != '0 && action != ACT_STOP)
    else $error("lamp lit without a tone");

endmodule

bind debounced_keypad_note_selector_unit dkns_checker u_dkns_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result_ch.valid),
  .out_ready (result_ch.ready),
  .action    (result_ch.action),
  .note      (result_ch.note),
  .freq      (result_ch.frequency_q4),
  .indicator (result_ch.indicator),
  .restart   (result_ch.restart)
);
